/* sv/block_bitmap_allocator_macros.svh */
// Assertion macros for the block bitmap allocator.
// Used by the top level; the clock is clk and the reset is arst_n.
`ifndef BLOCK_BITMAP_ALLOCATOR_MACROS_SVH
`define BLOCK_BITMAP_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define BBA_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define BBA_ASSERT_IMPL(lbl, ante, cons, msg)
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* sv/bba_pkg.sv */
// Shared constants, request codes and helpers for the block bitmap allocator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

	// Default geometry of the map.
	localparam int NUM_BLOCKS_DEF = 1024;
	localparam int WORD_BITS_DEF  = 8;

	// Widths of the request and result fields.
	localparam int KIND_W = 3;
	localparam int IDX_W  = 10;
	localparam int CNT_W  = 11;

	// Request codes.
	localparam logic [KIND_W-1:0] KIND_MARK_USED = 3'd0;
	localparam logic [KIND_W-1:0] KIND_MARK_FREE = 3'd1;
	localparam logic [KIND_W-1:0] KIND_TEST      = 3'd2;
	localparam logic [KIND_W-1:0] KIND_FIND      = 3'd3;
	localparam logic [KIND_W-1:0] KIND_CHECK     = 3'd4;

	// Number of bits needed to address a store of the given depth, at least one.
	function automatic int addr_w(input int depth);
		addr_w = (depth > 1) ? $clog2(depth) : 1;
	endfunction

endpackage

`default_nettype wire

/* sv/bba_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// Depends on bba_pkg for the address width helper.
`timescale 1ns / 1ps
`default_nettype none

module bba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [bba_pkg::addr_w(DEPTH)-1:0]     waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic [bba_pkg::addr_w(DEPTH)-1:0]     raddr,
	output logic      [WIDTH-1:0]                      rdata
);
	import bba_pkg::*;

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write first in program order; a read of the same word returns the old word.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* sv/block_bitmap_allocator.sv */
// Block bitmap allocator top level: sequencer around one map RAM (bba_ram, bba_pkg).
// Rejected, zero-count and unknown requests finish in the idle state; mark and test
// divide, read, modify and write back; check scans the whole map and find scans it
// until the first free block, the map read port scanning one word a cycle. A new
// request is taken only once the last one is done. Reset clears the map with busy
// high; done cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none

`include "block_bitmap_allocator_macros.svh"

module block_bitmap_allocator #(
	parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF,
	parameter int WORD_BITS  = bba_pkg::WORD_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [bba_pkg::KIND_W-1:0]  kind,
	input  wire logic [bba_pkg::IDX_W-1:0]   block_index,
	input  wire logic [bba_pkg::CNT_W-1:0]   block_count,
	output logic                             done,
	output logic                             bit_used,
	output logic                             found,
	output logic      [bba_pkg::IDX_W-1:0]   found_index,
	output logic                             enough_free,
	output logic                             range_error
);
	import bba_pkg::*;

	// Map geometry and derived widths.
	localparam int MAP_WORDS   = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW          = addr_w(MAP_WORDS);
	localparam int SW          = addr_w(WORD_BITS);
	localparam int BW          = $clog2(NUM_BLOCKS + WORD_BITS + 1);
	localparam int CW          = $clog2(NUM_BLOCKS + 1);
	localparam int PW          = $clog2(WORD_BITS + 1);
	// Exact reciprocal for splitting a block index into word and bit.
	localparam int RECIP_SHIFT = IDX_W + $clog2(WORD_BITS) + 1;
	localparam int RECIP       = ((2 ** RECIP_SHIFT) + WORD_BITS - 1) / WORD_BITS;
	localparam int PROD_W      = IDX_W + RECIP_SHIFT + 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_WORDS - 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_ADDR,
		ST_MODIFY,
		ST_SCAN
	} state_t;

	state_t              state_q;
	logic [AW-1:0]       clr_addr_q;
	logic [KIND_W-1:0]   kind_q;
	logic [IDX_W-1:0]    idx_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [IDX_W-1:0]    quot_q;
	logic [SW-1:0]       bitpos_q;
	logic [AW-1:0]       word_addr_q;
	logic [AW-1:0]       rd_addr_q;
	logic [BW-1:0]       rd_base_q;
	logic                issuing_q;
	logic                vld_s1;
	logic                last_s1;
	logic [BW-1:0]       base_s1;
	logic [CW-1:0]       free_cnt_q;

	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic [AW-1:0]       mem_raddr;
	logic [WORD_BITS-1:0] mem_rdata;

	logic [PROD_W-1:0]   recip_prod;
	logic [IDX_W-1:0]    quot_times_w;
	logic [IDX_W-1:0]    rem;
	logic [WORD_BITS-1:0] bit_mask;
	logic [WORD_BITS-1:0] in_range;
	logic [WORD_BITS-1:0] free_bits;
	logic [PW-1:0]       pop;
	logic [SW-1:0]       low;
	logic [CW-1:0]       cnt_sum;
	logic [BW-1:0]       hit_index;

	assign busy = (state_q != ST_IDLE);

	// Word and bit of the requested block: reciprocal multiply, then remainder.
	assign recip_prod   = PROD_W'(idx_q) * PROD_W'(RECIP);
	assign quot_times_w = quot_q * IDX_W'(WORD_BITS);
	assign rem          = idx_q - quot_times_w;
	assign bit_mask     = WORD_BITS'(1) << bitpos_q;

	// Free blocks of the word that has just been read, within the block range.
	always_comb begin
		in_range = '0;
		for (int s = 0; s < WORD_BITS; s++) begin
			in_range[s] = (32'(base_s1) + 32'(s)) < 32'(NUM_BLOCKS);
		end
		free_bits = ~mem_rdata & in_range;
		pop = '0;
		low = '0;
		for (int s = WORD_BITS - 1; s >= 0; s--) begin
			pop = pop + PW'(free_bits[s]);
			if (free_bits[s]) begin
				low = SW'(s);
			end
		end
		cnt_sum   = free_cnt_q + CW'(pop);
		hit_index = base_s1 + BW'(low);
	end

	// Map RAM access: clearing pass, write back of a mark, reads for lookups.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = word_addr_q;
		mem_wdata = (kind_q == KIND_MARK_USED) ? (mem_rdata | bit_mask)
		                                       : (mem_rdata & ~bit_mask);
		mem_raddr = rd_addr_q;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				mem_wdata = '0;
			end
			ST_ADDR: begin
				mem_raddr = AW'(quot_q);
			end
			ST_MODIFY: begin
				mem_we = (kind_q == KIND_MARK_USED) || (kind_q == KIND_MARK_FREE);
			end
			default: begin
			end
		endcase
	end

	bba_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (MAP_WORDS)
	) u_map (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Sequencer with registered result word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			kind_q      <= '0;
			idx_q       <= '0;
			cnt_q       <= '0;
			quot_q      <= '0;
			bitpos_q    <= '0;
			word_addr_q <= '0;
			rd_addr_q   <= '0;
			rd_base_q   <= '0;
			issuing_q   <= 1'b0;
			vld_s1      <= 1'b0;
			last_s1     <= 1'b0;
			base_s1     <= '0;
			free_cnt_q  <= '0;
			done        <= 1'b0;
			bit_used    <= 1'b0;
			found       <= 1'b0;
			found_index <= '0;
			enough_free <= 1'b0;
			range_error <= 1'b0;
		end else begin
			// A result word lasts a single cycle.
			done        <= 1'b0;
			bit_used    <= 1'b0;
			found       <= 1'b0;
			found_index <= '0;
			enough_free <= 1'b0;
			range_error <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						kind_q     <= kind;
						idx_q      <= block_index;
						cnt_q      <= block_count;
						rd_addr_q  <= '0;
						rd_base_q  <= '0;
						issuing_q  <= 1'b1;
						vld_s1     <= 1'b0;
						free_cnt_q <= '0;
						case (kind)
							KIND_MARK_USED, KIND_MARK_FREE, KIND_TEST: begin
								if (32'(block_index) >= 32'(NUM_BLOCKS)) begin
									done        <= 1'b1;
									range_error <= 1'b1;
								end else begin
									state_q <= ST_DIV;
								end
							end
							KIND_FIND: begin
								state_q <= ST_SCAN;
							end
							KIND_CHECK: begin
								if (32'(block_count) > 32'(NUM_BLOCKS)) begin
									done        <= 1'b1;
									range_error <= 1'b1;
								end else if (block_count == '0) begin
									done        <= 1'b1;
									enough_free <= 1'b1;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							default: begin
								done <= 1'b1;
							end
						endcase
					end
				end
				ST_DIV: begin
					quot_q  <= recip_prod[RECIP_SHIFT +: IDX_W];
					state_q <= ST_ADDR;
				end
				ST_ADDR: begin
					// The map read of the word is issued in this cycle.
					bitpos_q    <= rem[SW-1:0];
					word_addr_q <= AW'(quot_q);
					state_q     <= ST_MODIFY;
				end
				ST_MODIFY: begin
					done     <= 1'b1;
					bit_used <= (kind_q == KIND_TEST) && mem_rdata[bitpos_q];
					state_q  <= ST_IDLE;
				end
				ST_SCAN: begin
					// Issue one read a cycle until the last word.
					vld_s1  <= issuing_q;
					last_s1 <= (rd_addr_q == LAST_ADDR);
					base_s1 <= rd_base_q;
					if (issuing_q) begin
						rd_addr_q <= rd_addr_q + AW'(1);
						rd_base_q <= rd_base_q + BW'(WORD_BITS);
						if (rd_addr_q == LAST_ADDR) begin
							issuing_q <= 1'b0;
						end
					end
					// Evaluate the word read in the previous cycle.
					if (vld_s1) begin
						free_cnt_q <= cnt_sum;
						if (kind_q == KIND_FIND) begin
							if (free_bits != '0) begin
								done        <= 1'b1;
								found       <= 1'b1;
								found_index <= IDX_W'(hit_index);
								state_q     <= ST_IDLE;
							end else if (last_s1) begin
								done    <= 1'b1;
								state_q <= ST_IDLE;
							end
						end else if (last_s1) begin
							done        <= 1'b1;
							enough_free <= (32'(cnt_sum) >= 32'(cnt_q));
							state_q     <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The map is written only by the clearing pass or by a mark write back.
	`BBA_ASSERT_IMPL(a_we_phase, mem_we, (state_q == ST_CLEAR) || (state_q == ST_MODIFY), "map written outside clear or modify")
	// Any flag of a result appears only with the strobe.
	`BBA_ASSERT_IMPL(a_flags_done, bit_used || found || enough_free || range_error, done, "result flag without strobe")
	// Every request has finished by the cycle its result word is shown.
	`BBA_ASSERT_IMPL(a_done_idle, done, !busy, "result strobed while still busy")
	// A find request always starts a scan of the map.
	`BBA_ASSERT_NEXT(a_find_scan, start && !busy && (kind == KIND_FIND), state_q == ST_SCAN, "find did not start a scan")

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// Self-checking testbench for the block bitmap allocator, with its own model of the map.
// It depends on bba_pkg for the field widths and request codes, and on block_bitmap_allocator.
// A queue of requests, filled by an initial block, feeds a clocked driver; a clocked monitor checks.
`timescale 1ns / 1ps

module tb_top;

	import bba_pkg::*;

	localparam int NB = NUM_BLOCKS_DEF;

	// Request codes the block does not define; they must leave the map alone.
	localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
	localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [IDX_W-1:0]  idx;
		logic [CNT_W-1:0]  cnt;
	} alloc_req_t;

	typedef struct packed {
		logic             bit_used;
		logic             found;
		logic [IDX_W-1:0] found_index;
		logic             enough_free;
		logic             range_error;
	} alloc_res_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic [KIND_W-1:0] kind = '0;
	logic [IDX_W-1:0]  block_index = '0;
	logic [CNT_W-1:0]  block_count = '0;
	logic              busy;
	logic              done;
	logic              bit_used;
	logic              found;
	logic [IDX_W-1:0]  found_index;
	logic              enough_free;
	logic              range_error;

	// Model of the allocation map: one bit per block, 1 when used.
	logic [NB-1:0] used_map = '0;
	int            free_blocks = NB;

	alloc_req_t request_q[$];
	alloc_res_t result_q[$];

	alloc_req_t cur_req;
	alloc_res_t want;
	logic       taken = 1'b0;
	int         gap_left = 0;
	logic       calm = 1'b0;
	int         errors = 0;
	int         n_results = 0;
	int         n_kind[8];

	block_bitmap_allocator DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.kind        (kind),
		.block_index (block_index),
		.block_count (block_count),
		.done        (done),
		.bit_used    (bit_used),
		.found       (found),
		.found_index (found_index),
		.enough_free (enough_free),
		.range_error (range_error)
	);

	always #10 clk = ~clk;

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// Works out the result of one request and applies it to the model map.
	task automatic predict_result(input alloc_req_t r, output alloc_res_t e);
		e = '0;
		case (r.kind)
			KIND_MARK_USED, KIND_MARK_FREE: begin
				if (int'(r.idx) >= NB) begin
					e.range_error = 1'b1;
				end else begin
					if (used_map[r.idx] != (r.kind == KIND_MARK_USED))
						free_blocks += (r.kind == KIND_MARK_USED) ? -1 : 1;
					used_map[r.idx] = (r.kind == KIND_MARK_USED);
				end
			end
			KIND_TEST: begin
				if (int'(r.idx) >= NB)
					e.range_error = 1'b1;
				else
					e.bit_used = used_map[r.idx];
			end
			KIND_FIND: begin
				for (int b = 0; b < NB; b++) begin
					if (!e.found && !used_map[b]) begin
						e.found = 1'b1;
						e.found_index = IDX_W'(b);
					end
				end
			end
			KIND_CHECK: begin
				if (int'(r.cnt) > NB)
					e.range_error = 1'b1;
				else
					e.enough_free = (free_blocks >= int'(r.cnt));
			end
			default: begin
			end
		endcase
	endtask

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, actual %0d", name, exp_v, act_v);
			errors++;
		end
	endtask

	// Gap after a word: mostly none or short, now and then long enough to span a scan.
	function automatic int pick_gap(input logic quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 50)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 4);
		else
			return $urandom_range(20, 150);
	endfunction

	// Driver: presents the next request at the falling edge once the last one is taken.
	always @(negedge clk) begin
		if (arst_n && (!start || taken)) begin
			if (gap_left > 0) begin
				start <= 1'b0;
				gap_left <= gap_left - 1;
				kind <= KIND_W'($urandom);
				block_index <= IDX_W'($urandom);
				block_count <= CNT_W'($urandom);
			end else if (request_q.size() != 0) begin
				cur_req = request_q.pop_front();
				start <= 1'b1;
				kind <= cur_req.kind;
				block_index <= cur_req.idx;
				block_count <= cur_req.cnt;
				gap_left <= pick_gap(calm);
				if ($urandom_range(0, 149) == 0)
					calm <= !calm;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: checks each strobed result and predicts each accepted request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken <= 1'b0;
		end else begin
			taken <= start && !busy;
			if (done) begin
				if (result_q.size() == 0) begin
					$error("result strobed with no request outstanding");
					errors++;
				end else begin
					want = result_q.pop_front();
					check_field("bit_used", want.bit_used, bit_used);
					check_field("found", want.found, found);
					check_field("found_index", want.found_index, found_index);
					check_field("enough_free", want.enough_free, enough_free);
					check_field("range_error", want.range_error, range_error);
					n_results++;
				end
			end
			if (start && !busy) begin
				predict_result('{kind: kind, idx: block_index, cnt: block_count}, want);
				result_q.push_back(want);
				n_kind[kind]++;
			end
		end
	end

	task automatic push_req(input logic [KIND_W-1:0] k, input int i, input int c);
		request_q.push_back('{kind: k, idx: IDX_W'(i), cnt: CNT_W'(c)});
	endtask

	// Waits until every queued word has been taken, so the model map is current.
	task automatic drain_requests();
		while (request_q.size() != 0 || start)
			@(posedge clk);
	endtask

	// One random request; marks fall below lim, and mark_pct sets the share of mark used.
	task automatic gen_mixed(input int lim, input int mark_pct);
		int r;
		int i;
		int c;
		r = $urandom_range(0, 99);
		i = $urandom_range(0, lim - 1);
		c = $urandom_range(0, 2047);
		if (r < mark_pct) begin
			push_req(KIND_MARK_USED, i, c);
		end else if (r < 45) begin
			push_req(KIND_MARK_FREE, i, c);
		end else if (r < 58) begin
			push_req(KIND_TEST, $urandom_range(0, 1) ? i : $urandom_range(0, NB - 1), c);
		end else if (r < 72) begin
			push_req(KIND_FIND, $urandom_range(0, NB - 1), c);
		end else if (r < 92) begin
			case ($urandom_range(0, 4))
				0: c = 0;
				1: c = $urandom_range(1, NB);
				2: c = $urandom_range(NB + 1, 2047);
				default: begin
					// Aim at the exact boundary of the free count.
					drain_requests();
					c = free_blocks + $urandom_range(0, 1);
				end
			endcase
			push_req(KIND_CHECK, $urandom_range(0, NB - 1), c);
		end else begin
			push_req(KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)),
				$urandom_range(0, NB - 1), c);
		end
	endtask

	// Stimulus and end of run.
	initial begin
		int wait_cycles;

		// Directed: empty map, count limits, both ends of the map and the spare codes.
		push_req(KIND_FIND, NB - 1, 2047);
		push_req(KIND_CHECK, 0, 0);
		push_req(KIND_CHECK, 0, 1);
		push_req(KIND_CHECK, 0, NB);
		push_req(KIND_CHECK, 0, NB + 1);
		push_req(KIND_CHECK, NB - 1, 2047);
		push_req(KIND_TEST, 0, 0);
		push_req(KIND_TEST, NB - 1, 0);
		push_req(KIND_MARK_USED, 0, 2047);
		push_req(KIND_TEST, 0, 0);
		push_req(KIND_FIND, 0, 0);
		push_req(KIND_MARK_USED, NB - 1, 0);
		push_req(KIND_TEST, NB - 1, 0);
		push_req(KIND_CHECK, 0, NB - 2);
		push_req(KIND_CHECK, 0, NB - 1);
		push_req(KIND_MARK_FREE, 0, 0);
		push_req(KIND_FIND, 0, 0);
		push_req(KIND_TEST, 0, 0);
		push_req(KIND_MARK_USED, 'h2AA, 'h555);
		push_req(KIND_MARK_USED, 'h155, 'h2AA);
		for (int k = KIND_SPARE_LO; k <= KIND_SPARE_HI; k++)
			push_req(KIND_W'(k), NB - 1, 2047);
		push_req(KIND_MARK_FREE, NB - 1, 0);

		// Random mix with marks in a window that widens across the whole map.
		for (int n = 0; n < 500; n++)
			gen_mixed(8 + (n * (NB - 8)) / 499, 33);

		// Fill the map completely, looking for the lowest free block along the way.
		for (int b = 0; b < NB; b++) begin
			push_req(KIND_MARK_USED, b, $urandom_range(0, 2047));
			if (b % 128 == 127)
				push_req(KIND_FIND, $urandom_range(0, NB - 1), $urandom_range(0, 2047));
		end
		push_req(KIND_FIND, 0, 0);
		push_req(KIND_CHECK, 0, 1);
		push_req(KIND_CHECK, 0, 0);
		push_req(KIND_CHECK, 0, NB);
		push_req(KIND_TEST, $urandom_range(0, NB - 1), 0);

		// Random mix on a nearly full map, mostly freeing blocks.
		for (int n = 0; n < 300; n++)
			gen_mixed(NB, 15);

		drain_requests();
		wait_cycles = 0;
		while (result_q.size() != 0 && wait_cycles < 2000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (300) @(posedge clk);
		if (result_q.size() != 0) begin
			$error("%0d results never arrived", result_q.size());
			errors++;
		end

		$display("Sent %0d mark used, %0d mark free, %0d test, %0d find, %0d check requests",
			n_kind[KIND_MARK_USED], n_kind[KIND_MARK_FREE], n_kind[KIND_TEST],
			n_kind[KIND_FIND], n_kind[KIND_CHECK]);
		$display("and %0d with spare codes; %0d results compared, %0d mismatches.",
			n_kind[5] + n_kind[6] + n_kind[7], n_results, errors);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Watchdog: several times the slowest plausible run.
	initial begin
		#40000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
